>>> design/fmrc8_pkg.sv
// Shared types and constants for the framed message receiver with CRC-8.
package fmrc8_pkg;

  // Default field limits
  localparam int TOPIC_MAX_DEF   = 64;
  localparam int MESSAGE_MAX_DEF = 64;

  // Frame characters
  localparam logic [7:0] CH_LT   = 8'h3C;  // '<'
  localparam logic [7:0] CH_SEMI = 8'h3B;  // ';'
  localparam logic [7:0] CH_GT   = 8'h3E;  // '>'
  localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE = 8'h39;  // '9'

  // Printable range
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7E;

  // Field position limits
  localparam logic [8:0] LEN_POS_MAX  = 9'd3;
  localparam logic [8:0] TYPE_POS_MAX = 9'd5;

  // Reflected CRC-8 polynomial
  localparam logic [7:0] CRC_POLY = 8'h8C;

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_LEN   = 3'd1,
    M_TYPE  = 3'd2,
    M_TOPIC = 3'd3,
    M_MSG   = 3'd4,
    M_END   = 3'd5,
    M_CRC   = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    K_TYPE  = 3'd0,
    K_TOPIC = 3'd1,
    K_MSG   = 3'd2,
    K_OK    = 3'd3,
    K_BAD   = 3'd4,
    K_ABORT = 3'd5
  } kind_t;

  // Result of one parser step
  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] value;
  } res_t;

endpackage

>>> design/framed_message_receiver_crc8_top.sv
// Top level of the framed message receiver: input register, parser, result register.
//
//   channel  ports                                 direction
//   input    in_valid, in_stall, in_rx_byte        byte in
//   result   out_valid, out_stall, out_kind/value  result out
//
// One byte per cycle while in_stall is low; each request passes the input register,
// then one parser step with a byte CRC-8 into the result register.
// Synchronous active-low reset returns the parser to idle outside a frame.
// A stalled result holds; the parser steps only when the result register is
// free or being taken, and in_stall rises only while the input register is
// full and cannot move on.
module framed_message_receiver_crc8_top #(
  parameter int TOPIC_MAX   = fmrc8_pkg::TOPIC_MAX_DEF,
  parameter int MESSAGE_MAX = fmrc8_pkg::MESSAGE_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_value
);
  import fmrc8_pkg::*;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  kind_t      out_kind_r;
  logic [7:0] out_value_r;
  logic       advance;
  logic       step_w;
  res_t       res;

  // Pipeline moves when the result register is empty or drained
  assign advance  = !out_valid_r || !out_stall;
  assign step_w   = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
  end

  fmrc8_parser #(
    .TOPIC_MAX   (TOPIC_MAX),
    .MESSAGE_MAX (MESSAGE_MAX)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (step_w),
    .byte_i (in_byte_r),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step_w && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_w && res.valid) begin
      out_kind_r  <= res.kind;
      out_value_r <= res.value;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_value = out_value_r;

`ifndef SYNTHESIS
  // A buffered byte is kept while the result side blocks
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> (in_valid_r && $stable(in_byte_r)))
    else $error("buffered byte lost under stall");

  // A fresh result only comes from a parser step
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && out_stall)) |-> $past(step_w))
    else $error("result without a parser step");

  // Topic and message results carry the byte just parsed
  a_res_byte: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(step_w) && out_valid_r && (out_kind_r == K_TOPIC || out_kind_r == K_MSG))
    |-> (out_value_r == $past(in_byte_r)))
    else $error("payload result does not match parsed byte");
`endif

endmodule

>>> design/fmrc8_crc_unit.sv
// Byte-wide Dallas/Maxim CRC-8 update, reflected, one byte per call.
module fmrc8_crc_unit (
  input  logic [7:0] crc_i,
  input  logic [7:0] data_i,
  output logic [7:0] crc_o
);
  import fmrc8_pkg::*;

  // Eight shift steps over the byte, LSB first
  always_comb begin
    logic [7:0] c;
    c = crc_i ^ data_i;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

>>> design/fmrc8_parser.sv
// Frame parser: field tracking, length checks, CRC state and result decode.
module fmrc8_parser #(
  parameter int TOPIC_MAX   = fmrc8_pkg::TOPIC_MAX_DEF,
  parameter int MESSAGE_MAX = fmrc8_pkg::MESSAGE_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  output fmrc8_pkg::res_t  res_o
);
  import fmrc8_pkg::*;

  localparam int         LIMIT     = TOPIC_MAX + MESSAGE_MAX + 2;
  localparam logic [8:0] POS_LIMIT = 9'(LIMIT);

  typedef enum logic [2:0] {
    ACT_IGNORE,
    ACT_RESTART,
    ACT_ABORT,
    ACT_ADV,
    ACT_DONE
  } act_t;

  mode_t       mode_r, mode_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [9:0]  len_r, len_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  rcrc_r, rcrc_nxt;

  act_t        act;
  mode_t       mode_adv;
  logic [8:0]  pos;
  logic [10:0] pos_w;
  logic [10:0] len_p1;
  logic [10:0] len_p4;
  logic [7:0]  digit;
  logic [9:0]  len_acc;
  logic [7:0]  rcrc_acc;
  logic [7:0]  crc_seed;
  logic [7:0]  crc_calc;
  logic        is_start, is_semi, is_digit, is_print, over, beyond;

  // Character classes and position arithmetic
  assign is_start = (byte_i == CH_LT);
  assign is_semi  = (byte_i == CH_SEMI);
  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign is_print = (byte_i >= PRINT_LO) && (byte_i <= PRINT_HI);
  assign pos      = {1'b0, pos_r} + 9'd1;
  assign pos_w    = {2'b0, pos};
  assign len_p1   = {1'b0, len_r} + 11'd1;
  assign len_p4   = {1'b0, len_r} + 11'd4;
  assign over     = (pos > POS_LIMIT);
  assign beyond   = ({1'b0, pos} > len_r);
  assign digit    = byte_i - CH_ZERO;
  assign len_acc  = (len_r * 10'd10) + {6'b0, digit[3:0]};
  assign rcrc_acc = (rcrc_r * 8'd10) + digit;

  // CRC restarts from zero on the start mark
  assign crc_seed = is_start ? 8'h00 : crc_r;

  fmrc8_crc_unit u_crc (
    .crc_i  (crc_seed),
    .data_i (byte_i),
    .crc_o  (crc_calc)
  );

  // Step decode: what this byte does to the frame
  always_comb begin
    act      = ACT_IGNORE;
    mode_adv = mode_r;
    if (is_start) begin
      act = ACT_RESTART;
    end else if (mode_r == M_IDLE) begin
      act = ACT_IGNORE;
    end else if (over) begin
      act = ACT_ABORT;
    end else begin
      unique case (mode_r)
        M_LEN: begin
          if (is_semi) begin
            act      = ACT_ADV;
            mode_adv = M_TYPE;
          end else if (!is_digit || (pos > LEN_POS_MAX)) begin
            act = ACT_ABORT;
          end else begin
            act = ACT_ADV;
          end
        end
        M_TYPE: begin
          if (is_semi && (type_r != 8'h00)) begin
            act      = ACT_ADV;
            mode_adv = M_TOPIC;
          end else if (!is_print || (pos > TYPE_POS_MAX) || beyond) begin
            act = ACT_ABORT;
          end else begin
            act = ACT_ADV;
          end
        end
        M_TOPIC: begin
          if (is_semi) begin
            act      = ACT_ADV;
            mode_adv = M_MSG;
          end else if (!is_print || beyond) begin
            act = ACT_ABORT;
          end else begin
            act = ACT_ADV;
          end
        end
        M_MSG: begin
          if (!is_print || beyond) begin
            act = ACT_ABORT;
          end else begin
            act = ACT_ADV;
            if ({1'b0, pos} == len_r) begin
              mode_adv = M_END;
            end
          end
        end
        M_END: begin
          if ((byte_i == CH_GT) && (pos_w == len_p1)) begin
            act      = ACT_ADV;
            mode_adv = M_CRC;
          end else begin
            act = ACT_ABORT;
          end
        end
        M_CRC: begin
          act = (pos_w >= len_p4) ? ACT_DONE : ACT_ADV;
        end
        M_IDLE: begin
          act = ACT_IGNORE;
        end
        default: begin
          act = ACT_IGNORE;
        end
      endcase
    end
  end

  // Next state
  always_comb begin
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    len_nxt  = len_r;
    type_nxt = type_r;
    crc_nxt  = crc_r;
    rcrc_nxt = rcrc_r;
    unique case (act)
      ACT_RESTART: begin
        mode_nxt = M_LEN;
        pos_nxt  = 8'h00;
        len_nxt  = 10'h000;
        type_nxt = 8'h00;
        crc_nxt  = crc_calc;
        rcrc_nxt = 8'h00;
      end
      ACT_ABORT, ACT_DONE: begin
        mode_nxt = M_IDLE;
        pos_nxt  = 8'h00;
        len_nxt  = 10'h000;
        type_nxt = 8'h00;
        crc_nxt  = 8'h00;
        rcrc_nxt = 8'h00;
      end
      ACT_ADV: begin
        mode_nxt = mode_adv;
        pos_nxt  = pos[7:0];
        if (mode_r != M_CRC) begin
          crc_nxt = crc_calc;
        end
        if ((mode_r == M_LEN) && !is_semi) begin
          len_nxt = len_acc;
        end
        if ((mode_r == M_TYPE) && (mode_adv == M_TYPE)) begin
          type_nxt = byte_i;
        end
        if (mode_r == M_CRC) begin
          rcrc_nxt = rcrc_acc;
        end
      end
      ACT_IGNORE: begin
        mode_nxt = M_IDLE;
      end
      default: begin
        mode_nxt = M_IDLE;
      end
    endcase
  end

  // Result decode
  always_comb begin
    res_o.valid = 1'b0;
    res_o.kind  = K_ABORT;
    res_o.value = crc_r;
    unique case (act)
      ACT_RESTART: begin
        res_o.valid = (mode_r != M_IDLE);
      end
      ACT_ABORT: begin
        res_o.valid = 1'b1;
      end
      ACT_DONE: begin
        res_o.valid = 1'b1;
        res_o.kind  = (crc_r == rcrc_acc) ? K_OK : K_BAD;
      end
      ACT_ADV: begin
        if ((mode_r == M_TYPE) && (mode_adv == M_TOPIC)) begin
          res_o.valid = 1'b1;
          res_o.kind  = K_TYPE;
          res_o.value = type_r;
        end else if ((mode_r == M_TOPIC) && (mode_adv == M_TOPIC)) begin
          res_o.valid = 1'b1;
          res_o.kind  = K_TOPIC;
          res_o.value = byte_i;
        end else if (mode_r == M_MSG) begin
          res_o.valid = 1'b1;
          res_o.kind  = K_MSG;
          res_o.value = byte_i;
        end
      end
      ACT_IGNORE: begin
        res_o.valid = 1'b0;
      end
      default: begin
        res_o.valid = 1'b0;
      end
    endcase
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pos_r  <= 8'h00;
      len_r  <= 10'h000;
      type_r <= 8'h00;
      crc_r  <= 8'h00;
      rcrc_r <= 8'h00;
    end else if (step_i) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      len_r  <= len_nxt;
      type_r <= type_nxt;
      crc_r  <= crc_nxt;
      rcrc_r <= rcrc_nxt;
    end
  end

endmodule

>>> bench/tb_top.sv
// Testbench for the framed message receiver: directed and random byte streams against a predictor.
module tb_top;
  import fmrc8_pkg::*;

  localparam int FRAME_POS_MAX = TOPIC_MAX_DEF + MESSAGE_MAX_DEF + 2;
  localparam int RANDOM_BYTES  = 250;

  // How the trailing CRC digits of a built frame are made
  localparam int CRC_EXACT = 0;  // decimal digits of the CRC
  localparam int CRC_ALIAS = 1;  // CRC + 256 where it fits in three digits
  localparam int CRC_JUNK  = 2;  // arbitrary bytes

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
  } rx_result_t;

  typedef logic [7:0] octet_q_t[$];

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] out_kind;
  logic [7:0] out_value;

  // Parser model state
  mode_t      pm;
  logic [7:0] p_pos;
  logic [9:0] p_len;
  logic [7:0] p_type;
  logic [7:0] p_crc;
  logic [7:0] p_rxcrc;

  rx_result_t expected_q[$];
  int         err_count;
  int         bytes_sent;
  int         hold_req;
  bit         no_gaps;

  framed_message_receiver_crc8_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_value  (out_value)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Dallas/Maxim CRC-8, reflected, one byte
  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    int         i;
    c = crc ^ b;
    for (i = 0; i < 8; i++)
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic bit printable(logic [7:0] c);
    return c >= PRINT_LO && c <= PRINT_HI;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 3);
    if (r < 9) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Printable character that never restarts a frame
  function automatic logic [7:0] rand_char(bit semi_ok);
    logic [7:0] c;
    do
      c = 8'($urandom_range(PRINT_LO, PRINT_HI));
    while (c == CH_LT || (!semi_ok && c == CH_SEMI));
    return c;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic clear_frame_state();
    pm      = M_IDLE;
    p_pos   = '0;
    p_len   = '0;
    p_type  = '0;
    p_crc   = '0;
    p_rxcrc = '0;
  endtask

  task automatic expect_result(kind_t k, logic [7:0] v);
    rx_result_t r;
    r.kind  = k;
    r.value = v;
    expected_q.push_back(r);
  endtask

  task automatic drop_frame();
    expect_result(K_ABORT, p_crc);
    clear_frame_state();
  endtask

  // Parser step for one accepted byte
  task automatic predict_octet(logic [7:0] c);
    int pos;
    if (c == CH_LT) begin
      if (pm != M_IDLE) drop_frame();
      clear_frame_state();
      pm    = M_LEN;
      p_crc = crc8_update(8'h00, c);
      return;
    end
    if (pm == M_IDLE) return;
    pos = p_pos + 1;
    if (pos > FRAME_POS_MAX) begin
      drop_frame();
      return;
    end
    p_pos = pos[7:0];
    case (pm)
      M_LEN: begin
        if (c == CH_SEMI) begin
          pm = M_TYPE;
        end else if (c < CH_ZERO || c > CH_NINE || pos > LEN_POS_MAX) begin
          drop_frame();
          return;
        end else begin
          p_len = 10'(p_len * 10 + (c - CH_ZERO));
        end
        p_crc = crc8_update(p_crc, c);
      end
      M_TYPE: begin
        if (c == CH_SEMI && p_type != 0) begin
          pm    = M_TOPIC;
          p_crc = crc8_update(p_crc, c);
          expect_result(K_TYPE, p_type);
        end else if (!printable(c) || pos > TYPE_POS_MAX || pos > p_len) begin
          drop_frame();
        end else begin
          p_type = c;
          p_crc  = crc8_update(p_crc, c);
        end
      end
      M_TOPIC: begin
        if (c == CH_SEMI) begin
          pm    = M_MSG;
          p_crc = crc8_update(p_crc, c);
        end else if (!printable(c) || pos > p_len) begin
          drop_frame();
        end else begin
          p_crc = crc8_update(p_crc, c);
          expect_result(K_TOPIC, c);
        end
      end
      M_MSG: begin
        if (!printable(c) || pos > p_len) begin
          drop_frame();
        end else begin
          if (pos == p_len) pm = M_END;
          p_crc = crc8_update(p_crc, c);
          expect_result(K_MSG, c);
        end
      end
      M_END: begin
        if (c == CH_GT && pos == p_len + 1) begin
          pm    = M_CRC;
          p_crc = crc8_update(p_crc, c);
        end else begin
          drop_frame();
        end
      end
      default: begin
        // CRC digits are taken as they come and wrap mod 256
        p_rxcrc = 8'(p_rxcrc * 10 + (c - CH_ZERO));
        if (pos >= p_len + 4) begin
          if (p_crc == p_rxcrc)
            expect_result(K_OK, p_crc);
          else
            expect_result(K_BAD, p_crc);
          clear_frame_state();
        end
      end
    endcase
  endtask

  // Send one request, wait for it to be taken, then maybe leave a gap
  task automatic send_octet(logic [7:0] b);
    int gap;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    if (pm != M_IDLE || b == CH_LT) bytes_sent++;
    predict_octet(b);
    if (!no_gaps && $urandom_range(0, 99) < 25) begin
      gap = pick_gap();
      repeat (gap) begin
        @(negedge clk);
        in_valid   <= 1'b0;
        in_rx_byte <= 8'($urandom);
      end
    end
  endtask

  task automatic send_frame(octet_q_t f);
    foreach (f[i]) send_octet(f[i]);
  endtask

  task automatic send_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) send_octet(s[i]);
  endtask

  // Append three CRC characters over everything from '<' through '>'
  task automatic finish_frame(inout octet_q_t f, input int crc_mode);
    logic [7:0] crc;
    int         code;
    int         i;
    crc = 8'h00;
    foreach (f[j]) crc = crc8_update(crc, f[j]);
    code = int'(crc);
    if (crc_mode == CRC_ALIAS && code + 256 <= 999) code += 256;
    if (crc_mode == CRC_JUNK) begin
      for (i = 0; i < 3; i++)
        f.push_back($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(CH_ZERO, CH_NINE)));
    end else begin
      f.push_back(CH_ZERO + 8'(code / 100));
      f.push_back(CH_ZERO + 8'((code / 10) % 10));
      f.push_back(CH_ZERO + 8'(code % 10));
    end
  endtask

  // Well-formed frame; the length field is the position of the last message byte
  task automatic build_frame(output octet_q_t f, input int tlen, input int mlen,
                             input int ntype, input bit pad_len, input int crc_mode);
    int k;
    int dlen;
    int i;
    f    = {};
    k    = pad_len ? 3 : 1;
    dlen = k + 3 + ntype + tlen + mlen;
    if (!pad_len && dlen > 9) begin
      k = 2;
      dlen++;
    end
    if (!pad_len && dlen > 99) begin
      k = 3;
      dlen++;
    end
    f.push_back(CH_LT);
    for (i = k - 1; i >= 0; i--) f.push_back(CH_ZERO + 8'((dlen / (10 ** i)) % 10));
    f.push_back(CH_SEMI);
    for (i = 0; i < ntype; i++) f.push_back(rand_char(i == 0));
    f.push_back(CH_SEMI);
    for (i = 0; i < tlen; i++) f.push_back(rand_char(1'b0));
    f.push_back(CH_SEMI);
    for (i = 0; i < mlen; i++) f.push_back(rand_char(1'b1));
    f.push_back(CH_GT);
    finish_frame(f, crc_mode);
  endtask

  task automatic send_text_frame(string body, int crc_mode);
    octet_q_t f;
    int       i;
    f = {};
    for (i = 0; i < body.len(); i++) f.push_back(body[i]);
    finish_frame(f, crc_mode);
    send_frame(f);
  endtask

  // Receiver side: random stalls, quiet stretches, and a long hold when asked
  initial begin : result_sink
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        n        = hold_req;
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end else if (!no_gaps && $urandom_range(0, 99) < 20) begin
        n = pick_gap();
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Each taken result against the oldest prediction
  always @(posedge clk) begin : result_check
    rx_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d value %02h", out_kind, out_value));
      end else begin
        e = expected_q.pop_front();
        if (out_kind !== e.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", out_kind, e.kind));
        if (out_value !== e.value)
          report_mismatch($sformatf("value %02h, expected %02h (kind %0d)",
                                    out_value, e.value, e.kind));
      end
    end
  end

  task automatic test_good_frames();
    octet_q_t f;
    build_frame(f, 0, 1, 1, 1'b0, CRC_EXACT);  // shortest frame
    send_frame(f);
    build_frame(f, 3, 4, 2, 1'b0, CRC_EXACT);  // second type byte replaces the first
    send_frame(f);
    build_frame(f, 2, 2, 1, 1'b1, CRC_EXACT);  // length with leading zeros
    send_frame(f);
    send_text_frame("<6;;;;m>", CRC_EXACT);    // ';' taken as the type
  endtask

  task automatic test_crc_digits();
    octet_q_t f;
    build_frame(f, 2, 3, 1, 1'b0, CRC_JUNK);
    send_frame(f);
    send_text_frame("<6;A;;m>", CRC_ALIAS);    // digits wrap onto the right CRC
    send_text("<6;A;;m>999");
    send_text("<6;A;;m>a");
    send_octet(8'h00);
    send_octet(8'hFF);
  endtask

  task automatic test_idle_and_restart();
    send_octet(8'h00);
    send_octet(8'hFF);
    send_text(">;a");
    send_text("<12;x");
    send_text("<<");
    send_text_frame("<6;Q;;z>", CRC_EXACT);
  endtask

  task automatic test_length_errors();
    send_text("<1a");
    send_text("<1234");
    send_text("<;;");
    send_octet(CH_LT);
    send_octet(8'hB9);
  endtask

  task automatic test_type_errors();
    send_text("<9;");
    send_octet(8'h7F);
    send_text("<099;ab");   // type byte past position five
    send_text("<3;ab");     // type byte past the declared length
    send_text("<2;a");
  endtask

  task automatic test_field_errors();
    send_text("<20;T;ab");
    send_octet(8'h7F);
    send_text("<20;T;a;b");
    send_octet(8'h1F);
    send_text("<6;T;abc");  // topic runs past the declared length
    send_text("<5;T;a;b");  // message starts past the declared length
    send_text("<6;T;;mx");  // wrong end mark
    send_text("<6;T;;m>");
    send_octet(CH_LT);
  endtask

  task automatic test_over_length();
    octet_q_t f;
    int       i;
    // length 127: the last CRC digit lands one past the frame limit
    build_frame(f, 60, 60, 1, 1'b0, CRC_EXACT);
    send_frame(f);
    // declared length beyond the limit: cut off inside the message
    send_text("<200;T;;");
    for (i = 0; i < 124; i++) send_octet(rand_char(1'b1));
    send_octet(CH_LT);
  endtask

  task automatic test_largest_frames();
    octet_q_t f;
    build_frame(f, 60, 59, 1, 1'b0, CRC_EXACT);
    send_frame(f);
    build_frame(f, 0, 119, 1, 1'b0, CRC_EXACT);
    send_frame(f);
  endtask

  // Receiver holds off while a long frame keeps arriving back to back
  task automatic test_backpressure();
    octet_q_t f;
    no_gaps = 1'b1;
    build_frame(f, 10, 100, 1, 1'b0, CRC_EXACT);
    hold_req = 150;
    send_frame(f);
    no_gaps = 1'b0;
  endtask

  task automatic test_random_traffic();
    octet_q_t f;
    int       start;
    int       tlen;
    int       mlen;
    int       ntype;
    int       crc_mode;
    int       r;
    int       i;
    int       cut;
    bit       pad;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      no_gaps = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 9) == 0) begin
        tlen = $urandom_range(0, 60);
        mlen = $urandom_range(1, ($urandom_range(0, 3) == 0 ? 124 : 119) - tlen);
      end else begin
        tlen = $urandom_range(0, 8);
        mlen = $urandom_range(1, 12);
      end
      ntype    = (tlen + mlen < 80 && $urandom_range(0, 3) == 0) ? 2 : 1;
      pad      = (ntype == 1 && $urandom_range(0, 4) == 0);
      r        = $urandom_range(0, 9);
      crc_mode = (r < 7) ? CRC_EXACT : (r < 8) ? CRC_ALIAS : CRC_JUNK;
      build_frame(f, tlen, mlen, ntype, pad, crc_mode);
      r = $urandom_range(0, 99);
      if (r < 72) begin
        send_frame(f);
      end else if (r < 82) begin
        // one corrupted byte
        i    = $urandom_range(1, f.size() - 1);
        f[i] = $urandom_range(0, 1) ? rand_char(1'b1) : 8'($urandom_range(0, 255));
        send_frame(f);
      end else if (r < 90) begin
        // truncated; the next '<' aborts it
        cut = $urandom_range(1, f.size() - 1);
        for (i = 0; i < cut; i++) send_octet(f[i]);
      end else begin
        repeat ($urandom_range(1, 6)) send_octet(8'($urandom_range(0, 255)));
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    rst_n      = 1'b0;
    err_count  = 0;
    bytes_sent = 0;
    hold_req   = 0;
    no_gaps    = 1'b0;
    clear_frame_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_good_frames();
    test_crc_digits();
    test_idle_and_restart();
    test_length_errors();
    test_type_errors();
    test_field_errors();
    test_over_length();
    test_largest_frames();
    test_backpressure();
    test_random_traffic();

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
